[hw/rtl/pvalu_pkg.sv]
// Shared types and constants for the packed int16x8 vector ALU.
// No dependencies; used by pvalu_lane and packed_int16x8_vector_alu_top.
package pvalu_pkg;

  localparam int LANE_COUNT     = 8;
  localparam int LANE_WIDTH     = 16;
  localparam int HALF_WIDTH     = 64;
  localparam int LANES_PER_HALF = HALF_WIDTH / LANE_WIDTH;
  localparam int CMD_WIDTH      = 5;
  localparam int SHIFT_WIDTH    = 4;
  localparam int SHAMT_WIDTH    = 8;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_CONSTRUCT = 5'd0,
    CMD_SPLAT     = 5'd1,
    CMD_NEG       = 5'd2,
    CMD_NOT       = 5'd3,
    CMD_ADD       = 5'd4,
    CMD_SUB       = 5'd5,
    CMD_MUL       = 5'd6,
    CMD_AND       = 5'd7,
    CMD_OR        = 5'd8,
    CMD_XOR       = 5'd9,
    CMD_ADDS      = 5'd10,
    CMD_SUBS      = 5'd11,
    CMD_MIN       = 5'd12,
    CMD_MAX       = 5'd13,
    CMD_LT        = 5'd14,
    CMD_LE        = 5'd15,
    CMD_EQ        = 5'd16,
    CMD_NE        = 5'd17,
    CMD_GT        = 5'd18,
    CMD_GE        = 5'd19,
    CMD_SHL       = 5'd20,
    CMD_SAR       = 5'd21
  } cmd_t;

  typedef struct packed {
    logic [CMD_WIDTH-1:0]   command;
    logic [HALF_WIDTH-1:0]  first_low;
    logic [HALF_WIDTH-1:0]  first_high;
    logic [HALF_WIDTH-1:0]  second_low;
    logic [HALF_WIDTH-1:0]  second_high;
    logic [SHAMT_WIDTH-1:0] shift_amount;
  } op_beat_t;

  typedef struct packed {
    logic [HALF_WIDTH-1:0] result_low;
    logic [HALF_WIDTH-1:0] result_high;
  } res_beat_t;

endpackage

[hw/rtl/pvalu_lane.sv]
// One 16-bit signed lane of the vector ALU: all commands, purely combinational.
// Depends on pvalu_pkg for command codes and widths.
module pvalu_lane (
  input  logic [pvalu_pkg::CMD_WIDTH-1:0]   command,
  input  logic [pvalu_pkg::LANE_WIDTH-1:0]  a,
  input  logic [pvalu_pkg::LANE_WIDTH-1:0]  b,
  input  logic [pvalu_pkg::SHIFT_WIDTH-1:0] sh,
  output logic [pvalu_pkg::LANE_WIDTH-1:0]  r
);

  localparam int W = pvalu_pkg::LANE_WIDTH;
  localparam logic [W-1:0] SAT_MAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  logic [W:0]     sum_ext;
  logic [W:0]     diff_ext;
  logic [2*W-1:0] prod;
  logic [W-1:0]   sum_sat;
  logic [W-1:0]   diff_sat;
  logic           lt;
  logic           eq;

  assign sum_ext  = {a[W-1], a} + {b[W-1], b};
  assign diff_ext = {a[W-1], a} - {b[W-1], b};
  assign prod     = {{W{1'b0}}, a} * {{W{1'b0}}, b};
  assign lt       = $signed(a) < $signed(b);
  assign eq       = (a == b);

  // Overflow shows as the two top bits of the extended sum disagreeing.
  assign sum_sat  = (sum_ext[W] != sum_ext[W-1]) ? (sum_ext[W] ? SAT_MIN : SAT_MAX)
                                                 : sum_ext[W-1:0];
  assign diff_sat = (diff_ext[W] != diff_ext[W-1]) ? (diff_ext[W] ? SAT_MIN : SAT_MAX)
                                                   : diff_ext[W-1:0];

  always_comb begin
    unique case (command)
      pvalu_pkg::CMD_CONSTRUCT,
      pvalu_pkg::CMD_SPLAT:     r = a;
      pvalu_pkg::CMD_NEG:       r = (~a) + W'(1);
      pvalu_pkg::CMD_NOT:       r = ~a;
      pvalu_pkg::CMD_ADD:       r = sum_ext[W-1:0];
      pvalu_pkg::CMD_SUB:       r = diff_ext[W-1:0];
      pvalu_pkg::CMD_MUL:       r = prod[W-1:0];
      pvalu_pkg::CMD_AND:       r = a & b;
      pvalu_pkg::CMD_OR:        r = a | b;
      pvalu_pkg::CMD_XOR:       r = a ^ b;
      pvalu_pkg::CMD_ADDS:      r = sum_sat;
      pvalu_pkg::CMD_SUBS:      r = diff_sat;
      pvalu_pkg::CMD_MIN:       r = lt ? a : b;
      pvalu_pkg::CMD_MAX:       r = (!lt && !eq) ? a : b;
      pvalu_pkg::CMD_LT:        r = lt ? ALL_ONES : '0;
      pvalu_pkg::CMD_LE:        r = (lt || eq) ? ALL_ONES : '0;
      pvalu_pkg::CMD_EQ:        r = eq ? ALL_ONES : '0;
      pvalu_pkg::CMD_NE:        r = eq ? '0 : ALL_ONES;
      pvalu_pkg::CMD_GT:        r = (!lt && !eq) ? ALL_ONES : '0;
      pvalu_pkg::CMD_GE:        r = lt ? '0 : ALL_ONES;
      pvalu_pkg::CMD_SHL:       r = a << sh;
      pvalu_pkg::CMD_SAR:       r = W'($signed(a) >>> sh);
      default:                  r = '0;
    endcase
  end

endmodule

[hw/rtl/packed_int16x8_vector_alu_top.sv]
// Top level of the packed int16x8 vector ALU: operand register, eight lanes, result register.
// Depends on pvalu_pkg and pvalu_lane.
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+---------------------------------
//   op  (in) | op_valid  | op_stall  | op_beat  (pvalu_pkg::op_beat_t)
//   res (out)| res_valid | res_stall | res_beat (pvalu_pkg::res_beat_t)
//
// One beat per cycle sustained while res_stall is low; each beat passes through the
// operand register, the lanes and then the result register.
// The 16x16 lane multiplier sets the critical path.
// rst (synchronous) empties both registers; no other state exists.
// res_stall holds the result register and, once the operand register is full, stalls op.
module packed_int16x8_vector_alu_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_stall,
  input  pvalu_pkg::op_beat_t  op_beat,
  output logic                 res_valid,
  input  logic                 res_stall,
  output pvalu_pkg::res_beat_t res_beat
);

  localparam int W  = pvalu_pkg::LANE_WIDTH;
  localparam int LN = pvalu_pkg::LANE_COUNT;
  localparam int LH = pvalu_pkg::LANES_PER_HALF;

  logic                s1_valid;
  pvalu_pkg::op_beat_t s1_beat;
  logic                s1_free;
  logic                s2_free;
  logic                splat;
  logic [LN*W-1:0]     lane_result;

  assign s2_free  = !res_valid || !res_stall;
  assign s1_free  = !s1_valid || s2_free;
  assign op_stall = !s1_free;
  assign splat    = (s1_beat.command == pvalu_pkg::CMD_SPLAT);

  for (genvar i = 0; i < LN; i++) begin : g_lane
    localparam int K = i % LH;
    logic [W-1:0] a_lane;
    logic [W-1:0] b_lane;

    if (i < LH) begin : g_low
      assign a_lane = s1_beat.first_low[K*W +: W];
      assign b_lane = s1_beat.second_low[K*W +: W];
    end else begin : g_high
      assign a_lane = s1_beat.first_high[K*W +: W];
      assign b_lane = s1_beat.second_high[K*W +: W];
    end

    pvalu_lane u_lane (
      .command (s1_beat.command),
      .a       (splat ? s1_beat.first_low[W-1:0] : a_lane),
      .b       (b_lane),
      .sh      (s1_beat.shift_amount[pvalu_pkg::SHIFT_WIDTH-1:0]),
      .r       (lane_result[i*W +: W])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= op_valid;
      end
      if (s2_free) begin
        res_valid <= s1_valid;
      end
    end
  end

  // Payload registers: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (op_valid && s1_free) begin
      s1_beat <= op_beat;
    end
    if (s1_valid && s2_free) begin
      res_beat.result_low  <= lane_result[LH*W-1:0];
      res_beat.result_high <= lane_result[LN*W-1:LH*W];
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    op_stall |-> (s1_valid && res_valid && res_stall))
    else $error("op stalled while pipeline had room");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_stall) |=> s1_valid)
    else $error("accepted beat lost from operand register");

  a_s1_advances: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_free) |=> res_valid)
    else $error("operand beat did not reach result register");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!s1_valid && !res_valid))
    else $error("pipeline not empty after reset");

endmodule

[dv/packed_int16x8_vector_alu_top_tb.sv]
// Self-checking testbench for packed_int16x8_vector_alu_top: directed edge-value beats per
// command, then random beats with random idling on both channels, checked half by half.
// Depends on pvalu_pkg and the RTL of packed_int16x8_vector_alu_top.
module packed_int16x8_vector_alu_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pvalu_pkg::*;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned OP_ITEMS     = 1800;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_FIRST = CMD_WIDTH'(CMD_SAR + 1);
  localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_LAST  = '1;

  localparam logic signed [LANE_WIDTH:0] LANE_MAX = 17'sd32767;
  localparam logic signed [LANE_WIDTH:0] LANE_MIN = -17'sd32768;

  // Lanes 7..0, chosen so saturation, equality and sign edges all show up.
  localparam logic [2*HALF_WIDTH-1:0] EDGE_A = {16'h1234, 16'h7FFF, 16'h8000, 16'h0001,
                                                16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
  localparam logic [2*HALF_WIDTH-1:0] EDGE_B = {16'hFEDC, 16'h0001, 16'h8000, 16'h0001,
                                                16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF};

  class alu_result_scoreboard;
    res_beat_t   pending[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function logic [LANE_WIDTH-1:0] lane_result(logic [CMD_WIDTH-1:0] cmd,
                                                logic [LANE_WIDTH-1:0] a,
                                                logic [LANE_WIDTH-1:0] b,
                                                logic [SHIFT_WIDTH-1:0] sh);
      logic signed [LANE_WIDTH-1:0] sa;
      logic signed [LANE_WIDTH-1:0] sb;
      logic signed [LANE_WIDTH:0]   wide;
      sa = a;
      sb = b;
      case (cmd)
        CMD_CONSTRUCT, CMD_SPLAT: return a;
        CMD_NEG: return ~a + 1'b1;
        CMD_NOT: return ~a;
        CMD_ADD: return a + b;
        CMD_SUB: return a - b;
        CMD_MUL: return a * b;
        CMD_AND: return a & b;
        CMD_OR:  return a | b;
        CMD_XOR: return a ^ b;
        CMD_ADDS, CMD_SUBS: begin
          wide = (cmd == CMD_ADDS) ? sa + sb : sa - sb;
          if (wide > LANE_MAX) return LANE_MAX[LANE_WIDTH-1:0];
          if (wide < LANE_MIN) return LANE_MIN[LANE_WIDTH-1:0];
          return wide[LANE_WIDTH-1:0];
        end
        CMD_MIN: return (sa < sb) ? a : b;
        CMD_MAX: return (sa > sb) ? a : b;
        CMD_LT:  return {LANE_WIDTH{sa < sb}};
        CMD_LE:  return {LANE_WIDTH{sa <= sb}};
        CMD_EQ:  return {LANE_WIDTH{sa == sb}};
        CMD_NE:  return {LANE_WIDTH{sa != sb}};
        CMD_GT:  return {LANE_WIDTH{sa > sb}};
        CMD_GE:  return {LANE_WIDTH{sa >= sb}};
        CMD_SHL: return a << sh;
        CMD_SAR: return sa >>> sh;
        default: return '0;
      endcase
    endfunction

    function res_beat_t predict_vector(op_beat_t op);
      logic [2*HALF_WIDTH-1:0] a_vec;
      logic [2*HALF_WIDTH-1:0] b_vec;
      logic [2*HALF_WIDTH-1:0] r_vec;
      logic [LANE_WIDTH-1:0]   a_lane;
      res_beat_t               r;
      a_vec = {op.first_high, op.first_low};
      b_vec = {op.second_high, op.second_low};
      for (int i = 0; i < LANE_COUNT; i++) begin
        a_lane = (op.command == CMD_SPLAT) ? a_vec[LANE_WIDTH-1:0]
                                           : a_vec[LANE_WIDTH*i +: LANE_WIDTH];
        r_vec[LANE_WIDTH*i +: LANE_WIDTH] =
          lane_result(op.command, a_lane, b_vec[LANE_WIDTH*i +: LANE_WIDTH],
                      op.shift_amount[SHIFT_WIDTH-1:0]);
      end
      r.result_low  = r_vec[HALF_WIDTH-1:0];
      r.result_high = r_vec[2*HALF_WIDTH-1:HALF_WIDTH];
      return r;
    endfunction

    function void note_op(op_beat_t op);
      pending.push_back(predict_vector(op));
    endfunction

    function void field_mismatch(string field, logic [HALF_WIDTH-1:0] want,
                                 logic [HALF_WIDTH-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $realtime, field, want, got);
    endfunction

    function void check_result(res_beat_t got);
      res_beat_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with none expected: low %h high %h",
                   $realtime, got.result_low, got.result_high);
        return;
      end
      want = pending.pop_front();
      if (got.result_low !== want.result_low)
        field_mismatch("result_low", want.result_low, got.result_low);
      if (got.result_high !== want.result_high)
        field_mismatch("result_high", want.result_high, got.result_high);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      op_valid  = 1'b0;
  logic      op_stall;
  op_beat_t  op_beat   = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_beat_t res_beat;

  int unsigned          idle_cycles = 0;
  alu_result_scoreboard board       = new();

  packed_int16x8_vector_alu_top dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op_beat   (op_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LANE_WIDTH-1:0] pick_lane();
    case ($urandom_range(0, 9))
      6:       return 16'h8000;
      7:       return 16'h7FFF;
      8:       return 16'hFFFF;
      9:       return 16'h0001;
      default: return LANE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic op_beat_t build_op(logic [CMD_WIDTH-1:0] cmd,
                                        logic [2*HALF_WIDTH-1:0] a_vec,
                                        logic [2*HALF_WIDTH-1:0] b_vec,
                                        logic [SHAMT_WIDTH-1:0] shamt);
    op_beat_t op;
    op.command      = cmd;
    op.first_low    = a_vec[HALF_WIDTH-1:0];
    op.first_high   = a_vec[2*HALF_WIDTH-1:HALF_WIDTH];
    op.second_low   = b_vec[HALF_WIDTH-1:0];
    op.second_high  = b_vec[2*HALF_WIDTH-1:HALF_WIDTH];
    op.shift_amount = shamt;
    return op;
  endfunction

  function automatic op_beat_t random_op();
    logic [2*HALF_WIDTH-1:0] a_vec;
    logic [2*HALF_WIDTH-1:0] b_vec;
    logic [CMD_WIDTH-1:0]    cmd;
    if ($urandom_range(0, 19) == 0)
      cmd = CMD_WIDTH'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    else
      cmd = CMD_WIDTH'($urandom_range(CMD_CONSTRUCT, CMD_SAR));
    if ($urandom_range(0, 2) == 0) begin
      a_vec = {$urandom, $urandom, $urandom, $urandom};
      b_vec = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      for (int i = 0; i < LANE_COUNT; i++) begin
        a_vec[LANE_WIDTH*i +: LANE_WIDTH] = pick_lane();
        // copy some lanes across so equal operands occur often
        b_vec[LANE_WIDTH*i +: LANE_WIDTH] = ($urandom_range(0, 4) == 0)
                                            ? a_vec[LANE_WIDTH*i +: LANE_WIDTH]
                                            : pick_lane();
      end
    end
    return build_op(cmd, a_vec, b_vec, SHAMT_WIDTH'($urandom_range(0, 255)));
  endfunction

  task automatic send_op(input op_beat_t op, input int unsigned gap);
    if (gap != 0) begin
      op_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_valid <= 1'b1;
    op_beat  <= op;
    do @(posedge clk); while (op_stall);
    board.note_op(op);
  endtask

  initial begin : op_side
    logic [SHAMT_WIDTH-1:0] shamt;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int c = CMD_CONSTRUCT; c <= CMD_SAR; c++) begin
      shamt = (c == CMD_SHL) ? 8'h0F : 8'h11;
      send_op(build_op(CMD_WIDTH'(c), EDGE_A, EDGE_B, shamt), 0);
    end
    // count wraps modulo 16: 255 acts as 15, 16 as 0
    send_op(build_op(CMD_SAR, EDGE_A, '1, 8'hFF), 0);
    send_op(build_op(CMD_SHL, '1, '0, 8'h10), 0);
    send_op(build_op(CMD_NEG, {LANE_COUNT{16'h8000}}, '1, 8'h00), 0);
    send_op(build_op(CMD_SPLAT, '1, '1, 8'hFF), 0);
    send_op(build_op(CMD_UNUSED_FIRST, '1, '1, 8'hFF), 0);
    send_op(build_op(CMD_UNUSED_LAST, '1, '1, 8'hFF), 0);

    for (int n = 0; n < OP_ITEMS; n++) begin
      if (n == OP_ITEMS / 2) begin
        // drain the pipe completely before carrying on
        op_valid <= 1'b0;
        do @(posedge clk); while (board.pending.size() != 0);
      end
      send_op(random_op(), ((n / 100) % 4 == 0) ? 0 : idle_len());
    end
    op_valid <= 1'b0;

    do @(posedge clk); while (board.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : res_side
    int unsigned stall_len;
    int unsigned open_len;
    bit          held;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && board.results_seen >= HOLD_AFTER) begin
        // hold off long enough for the block to back up into op_stall
        held      = 1'b1;
        stall_len = HOLD_CYCLES;
      end else begin
        stall_len = idle_len();
      end
      open_len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
      if (stall_len != 0) begin
        res_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      res_stall <= 1'b0;
      repeat (open_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      board.check_result(res_beat);
  end

  always @(posedge clk) begin
    if (rst || (op_valid && !op_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
